[hdl/windowed_duration_stats_defines.svh]
// Assertion macros for the windowed duration statistics port checker
`ifndef WINDOWED_DURATION_STATS_DEFINES_SVH
`define WINDOWED_DURATION_STATS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define WDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("windowed_duration_stats: assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define WDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("windowed_duration_stats: assertion failed");

`endif

[hdl/wds_pkg.sv]
// Shared constants and control types for the windowed duration statistics block
`default_nettype none

package wds_pkg;

  // Parameter defaults
  localparam int DURATION_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF    = 16;

  // Configuration register
  localparam int              CFG_BITS       = 16;
  localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd120;

  // Item operation codes carried in tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input item this cycle
    logic step;      // advance both dividers by one quotient bit
    logic load_out;  // move the finished report into the output register
  } wds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic report_due;  // the item at the input produces a report
  } wds_status_t;

endpackage

`default_nettype wire

[hdl/wds_datapath.sv]
// Window accumulators, report snapshot, two restoring dividers and output register
`default_nettype none

module wds_datapath #(
  parameter int DURATION_BITS = wds_pkg::DURATION_BITS_DEF,
  parameter int COUNT_BITS    = wds_pkg::COUNT_BITS_DEF,
  parameter int IN_W          = 64,
  parameter int OUT_W         = 144
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wds_pkg::wds_cmd_t            cmd,
  output wds_pkg::wds_status_t         status,
  input  wire [IN_W-1:0]               s_tdata,
  input  wire                          s_tuser,
  input  wire                          cfg_valid,
  input  wire [wds_pkg::CFG_BITS-1:0]  cfg_data,
  output logic [OUT_W-1:0]             m_tdata
);
  import wds_pkg::*;

  localparam int DB    = DURATION_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int SB    = DB + CB;
  localparam int CMP_W = (CB > CFG_BITS) ? CB : CFG_BITS;

  // Window state
  logic [CFG_BITS-1:0] interval;
  logic [CB-1:0]       tally;
  logic [SB-1:0]       build_sum;
  logic [SB-1:0]       present_sum;
  logic [DB-1:0]       build_high;
  logic [DB-1:0]       present_high;

  // Report snapshot and dividers
  logic [CB-1:0]       div_count;
  logic [SB-1:0]       build_quo;
  logic [SB-1:0]       present_quo;
  logic [CB-1:0]       build_rem;
  logic [CB-1:0]       present_rem;
  logic [DB-1:0]       rep_build_max;
  logic [DB-1:0]       rep_present_max;

  // Combinational values
  logic [DB-1:0]       build_in;
  logic [DB-1:0]       present_in;
  logic                is_flush;
  logic [CB-1:0]       tally_inc;
  logic [SB:0]         build_add;
  logic [SB:0]         present_add;
  logic [CB-1:0]       cand_tally;
  logic [SB-1:0]       cand_build_sum;
  logic [SB-1:0]       cand_present_sum;
  logic [DB-1:0]       cand_build_high;
  logic [DB-1:0]       cand_present_high;
  logic [CFG_BITS-1:0] interval_eff;
  logic                report_due;
  logic                clear_window;
  logic [CB:0]         build_shift;
  logic [CB:0]         present_shift;
  logic                build_fits;
  logic                present_fits;
  logic [CB:0]         build_diff;
  logic [CB:0]         present_diff;
  logic [DB-1:0]       build_avg;
  logic [DB-1:0]       present_avg;
  logic [OUT_W-1:0]    out_word;

  // Unpack the item
  assign build_in   = s_tdata[DB-1:0];
  assign present_in = s_tdata[2*DB-1:DB];
  assign is_flush   = (s_tuser == OP_FLUSH);

  // Saturating updates of count and totals
  assign tally_inc   = (&tally) ? tally : tally + CB'(1);
  assign build_add   = {1'b0, build_sum} + (SB+1)'(build_in);
  assign present_add = {1'b0, present_sum} + (SB+1)'(present_in);

  // Window as it stands after this item; a flush leaves it as is
  always_comb begin
    if (is_flush) begin
      cand_tally        = tally;
      cand_build_sum    = build_sum;
      cand_present_sum  = present_sum;
      cand_build_high   = build_high;
      cand_present_high = present_high;
    end else begin
      cand_tally        = tally_inc;
      cand_build_sum    = build_add[SB] ? {SB{1'b1}} : build_add[SB-1:0];
      cand_present_sum  = present_add[SB] ? {SB{1'b1}} : present_add[SB-1:0];
      cand_build_high   = (build_in > build_high) ? build_in : build_high;
      cand_present_high = (present_in > present_high) ? present_in : present_high;
    end
  end

  // Decide whether this item reports; an interval of zero acts as one
  assign interval_eff = (interval == '0) ? CFG_BITS'(1) : interval;
  assign report_due   = is_flush ? (tally != '0)
                                 : (CMP_W'(tally_inc) >= CMP_W'(interval_eff));
  assign clear_window = report_due || is_flush;
  assign status.report_due = report_due;

  // Hold the report interval
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      interval <= cfg_data;
    end
  end

  // Advance or clear the window on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      tally        <= '0;
      build_sum    <= '0;
      present_sum  <= '0;
      build_high   <= '0;
      present_high <= '0;
    end else if (cmd.accept) begin
      if (clear_window) begin
        tally        <= '0;
        build_sum    <= '0;
        present_sum  <= '0;
        build_high   <= '0;
        present_high <= '0;
      end else begin
        tally        <= cand_tally;
        build_sum    <= cand_build_sum;
        present_sum  <= cand_present_sum;
        build_high   <= cand_build_high;
        present_high <= cand_present_high;
      end
    end
  end

  // One restoring division step per lane, shared divisor
  assign build_shift   = {build_rem, build_quo[SB-1]};
  assign present_shift = {present_rem, present_quo[SB-1]};
  assign build_fits    = (build_shift >= {1'b0, div_count});
  assign present_fits  = (present_shift >= {1'b0, div_count});
  assign build_diff    = build_fits ? build_shift - {1'b0, div_count} : build_shift;
  assign present_diff  = present_fits ? present_shift - {1'b0, div_count} : present_shift;

  // Snapshot the window on a report, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (cmd.accept && report_due) begin
      div_count       <= cand_tally;
      build_quo       <= cand_build_sum;
      present_quo     <= cand_present_sum;
      build_rem       <= '0;
      present_rem     <= '0;
      rep_build_max   <= cand_build_high;
      rep_present_max <= cand_present_high;
    end else if (cmd.step) begin
      build_quo   <= {build_quo[SB-2:0], build_fits};
      present_quo <= {present_quo[SB-2:0], present_fits};
      build_rem   <= build_diff[CB-1:0];
      present_rem <= present_diff[CB-1:0];
    end
  end

  // Saturate each average at the largest duration
  assign build_avg   = (|build_quo[SB-1:DB]) ? {DB{1'b1}} : build_quo[DB-1:0];
  assign present_avg = (|present_quo[SB-1:DB]) ? {DB{1'b1}} : present_quo[DB-1:0];

  // Pack the report, lowest field first
  always_comb begin
    out_word                     = '0;
    out_word[CB-1:0]             = div_count;
    out_word[CB+DB-1:CB]         = build_avg;
    out_word[CB+2*DB-1:CB+DB]    = rep_build_max;
    out_word[CB+3*DB-1:CB+2*DB]  = present_avg;
    out_word[CB+4*DB-1:CB+3*DB]  = rep_present_max;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= out_word;
    end
  end

endmodule

`default_nettype wire

[hdl/wds_ctrl.sv]
// Controller: item intake, division sequencing and output register handshake
`default_nettype none

module wds_ctrl #(
  parameter int SUM_BITS = wds_pkg::DURATION_BITS_DEF + wds_pkg::COUNT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  input  wds_pkg::wds_status_t  status,
  output wds_pkg::wds_cmd_t     cmd
);
  import wds_pkg::*;

  localparam int CNT_W = $clog2(SUM_BITS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] step_count;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.report_due) begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_count == CNT_W'(SUM_BITS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count division steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
    end else if (cmd.accept) begin
      step_count <= '0;
    end else if (cmd.step) begin
      step_count <= step_count + CNT_W'(1);
    end
  end

  // Output valid: set on load, drop when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/windowed_duration_stats.sv]
// Top level of the windowed duration statistics block
//
// Use: each input item on the s_ stream is either a record (tuser = 0) carrying
// one frame's build and present durations, or a flush (tuser = 1). Records are
// counted, summed and peak-tracked; when the count reaches report_interval a
// report item goes out on the m_ stream and the window clears. A flush reports
// a partial window if it holds a frame, and always clears it.
// The cfg_ channel writes report_interval (reset 120); cfg_ready is always high
// and writes are meant only while the block is idle.
// An item that does not report is taken while the block is idle, and the next
// can follow at once. A reporting item is snapshotted, then runs the two
// restoring dividers (DURATION_BITS + COUNT_BITS steps, one quotient bit per
// cycle); the report then moves into the output register on m_tdata once that
// register is free, and the input is not ready until the report is loaded.
// Reset (synchronous, rst high) empties the window, restores the interval and
// drops m_tvalid. A stalled receiver holds the report in the output register;
// the block still takes items, and a second report waits after its division
// until the output register is free.
`default_nettype none

module windowed_duration_stats #(
  parameter int DURATION_BITS = wds_pkg::DURATION_BITS_DEF,
  parameter int COUNT_BITS    = wds_pkg::COUNT_BITS_DEF,
  parameter int IN_W          = ((2 * DURATION_BITS + 7) / 8) * 8,
  parameter int OUT_W         = ((COUNT_BITS + 4 * DURATION_BITS + 7) / 8) * 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // build_duration, present_duration (zero padded to bytes)
  input  wire [IN_W-1:0]               s_tdata,
  // operation
  input  wire                          s_tuser,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // frames_in_report, build_average, build_max, present_average, present_max
  output logic [OUT_W-1:0]             m_tdata,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [wds_pkg::CFG_BITS-1:0]  cfg_data
);
  import wds_pkg::*;

  wds_cmd_t    cmd;
  wds_status_t status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  // Sequence intake, division and output
  wds_ctrl #(
    .SUM_BITS (DURATION_BITS + COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Accumulate, divide and hold the report
  wds_datapath #(
    .DURATION_BITS (DURATION_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .IN_W          (IN_W),
    .OUT_W         (OUT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

[hdl/wds_checker.sv]
// Port-level checks for the windowed duration statistics block, bound to the top level
`default_nettype none
`include "windowed_duration_stats_defines.svh"

module wds_checker #(
  parameter int DURATION_BITS = 32,
  parameter int COUNT_BITS    = 16,
  parameter int IN_W          = 64,
  parameter int OUT_W         = 144
) (
  input wire              clk,
  input wire              rst,
  input wire              s_tvalid,
  input wire              s_tready,
  input wire [IN_W-1:0]   s_tdata,
  input wire              s_tuser,
  input wire              m_tvalid,
  input wire              m_tready,
  input wire [OUT_W-1:0]  m_tdata,
  input wire              cfg_valid,
  input wire              cfg_ready,
  input wire [15:0]       cfg_data
);

  localparam int DB = DURATION_BITS;
  localparam int CB = COUNT_BITS;

  logic [CB-1:0] frames;
  logic [DB-1:0] build_avg;
  logic [DB-1:0] build_max;
  logic [DB-1:0] present_avg;
  logic [DB-1:0] present_max;

  // Unpack the report
  assign frames      = m_tdata[CB-1:0];
  assign build_avg   = m_tdata[CB+DB-1:CB];
  assign build_max   = m_tdata[CB+2*DB-1:CB+DB];
  assign present_avg = m_tdata[CB+3*DB-1:CB+2*DB];
  assign present_max = m_tdata[CB+4*DB-1:CB+3*DB];

  // A stalled report holds
  `WDS_ASSERT_NXT(a_report_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A report always covers at least one frame
  `WDS_ASSERT_IMP(a_frames_nonzero, m_tvalid, frames != '0)

  // An average never exceeds the peak of its window
  `WDS_ASSERT_IMP(a_build_avg_le_max, m_tvalid, build_avg <= build_max)
  `WDS_ASSERT_IMP(a_present_avg_le_max, m_tvalid, present_avg <= present_max)

endmodule

bind windowed_duration_stats wds_checker #(
  .DURATION_BITS (DURATION_BITS),
  .COUNT_BITS    (COUNT_BITS),
  .IN_W          (IN_W),
  .OUT_W         (OUT_W)
) u_wds_checker (.*);

`default_nettype wire

[test/wds_report_checker.sv]
// Checker that predicts windowed duration reports and compares them with the block
module wds_report_checker
  import wds_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  input  wire                 s_tready,
  // build_duration, present_duration
  input  wire [63:0]          s_tdata,
  // operation
  input  wire                 s_tuser,
  input  wire                 m_tvalid,
  input  wire                 m_tready,
  // frames_in_report, build_average, build_max, present_average, present_max
  input  wire [143:0]         m_tdata,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  wire [CFG_BITS-1:0]  cfg_data,
  output int                  mismatches,
  output int                  reports_owed
);

  localparam int DUR_W = DURATION_BITS_DEF;
  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int SUM_W = DUR_W + CNT_W;

  // One report, lowest field in the lowest bits, as on m_tdata
  typedef struct packed {
    logic [DUR_W-1:0] present_max;
    logic [DUR_W-1:0] present_average;
    logic [DUR_W-1:0] build_max;
    logic [DUR_W-1:0] build_average;
    logic [CNT_W-1:0] frames_in_report;
  } report_t;

  logic [CFG_BITS-1:0] interval_reg;
  logic [CNT_W-1:0]    tally;
  logic [SUM_W-1:0]    build_total;
  logic [SUM_W-1:0]    present_total;
  logic [DUR_W-1:0]    build_peak;
  logic [DUR_W-1:0]    present_peak;
  report_t             owed_reports[$];
  report_t             got;
  report_t             want;

  // Add a duration to a running total, pinned at the all-ones value
  function automatic logic [SUM_W-1:0] add_saturated(logic [SUM_W-1:0] acc,
                                                     logic [DUR_W-1:0] dur);
    logic [SUM_W:0] wide;
    wide = {1'b0, acc} + {{(CNT_W + 1){1'b0}}, dur};
    return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
  endfunction

  // Truncated mean, pinned at the largest duration
  function automatic logic [DUR_W-1:0] mean_of(logic [SUM_W-1:0] total,
                                               logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] q;
    if (n == '0) return '0;
    q = total / {{DUR_W{1'b0}}, n};
    if (q > {{CNT_W{1'b0}}, {DUR_W{1'b1}}}) return {DUR_W{1'b1}};
    return q[DUR_W-1:0];
  endfunction

  function automatic void clear_window();
    tally         = '0;
    build_total   = '0;
    present_total = '0;
    build_peak    = '0;
    present_peak  = '0;
  endfunction

  // Queue the report for the current window and empty it
  function automatic void close_window();
    report_t rep;
    rep.frames_in_report = tally;
    rep.build_average    = mean_of(build_total, tally);
    rep.build_max        = build_peak;
    rep.present_average  = mean_of(present_total, tally);
    rep.present_max      = present_peak;
    owed_reports.push_back(rep);
    clear_window();
  endfunction

  // Fold one accepted item into the window
  function automatic void absorb_item(logic op, logic [DUR_W-1:0] build_ns,
                                      logic [DUR_W-1:0] present_ns);
    logic [CNT_W-1:0] threshold;
    if (op == OP_FLUSH) begin
      if (tally != '0) close_window();
      clear_window();
    end else begin
      if (tally != {CNT_W{1'b1}}) tally = tally + 1'b1;
      build_total   = add_saturated(build_total, build_ns);
      present_total = add_saturated(present_total, present_ns);
      if (build_ns > build_peak) build_peak = build_ns;
      if (present_ns > present_peak) present_peak = present_ns;
      // a zero interval behaves as one
      threshold = (interval_reg == '0) ? CNT_W'(1) : CNT_W'(interval_reg);
      if (tally >= threshold) close_window();
    end
  endfunction

  function automatic void check_field(string field, logic [DUR_W-1:0] exp_val,
                                      logic [DUR_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Compare results first, then take config and input items of the same edge
  always @(posedge clk) begin
    if (rst) begin
      interval_reg = INTERVAL_RESET;
      clear_window();
      owed_reports.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (owed_reports.size() == 0) begin
          $error("unexpected report: frames_in_report %0d", got.frames_in_report);
          mismatches++;
        end else begin
          want = owed_reports.pop_front();
          check_field("frames_in_report", {16'd0, want.frames_in_report},
                      {16'd0, got.frames_in_report});
          check_field("build_average", want.build_average, got.build_average);
          check_field("build_max", want.build_max, got.build_max);
          check_field("present_average", want.present_average, got.present_average);
          check_field("present_max", want.present_max, got.present_max);
        end
      end
      if (cfg_valid && cfg_ready) interval_reg = cfg_data;
      if (s_tvalid && s_tready) absorb_item(s_tuser, s_tdata[31:0], s_tdata[63:32]);
    end
    reports_owed = owed_reports.size();
  end

endmodule

[test/windowed_duration_stats_tb.sv]
// Testbench top for the windowed duration statistics block: stimulus and verdict
module windowed_duration_stats_tb;
  import wds_pkg::*;

  localparam int DUR_W          = DURATION_BITS_DEF;
  localparam int IN_W           = ((2 * DUR_W + 7) / 8) * 8;
  localparam int OUT_W          = ((COUNT_BITS_DEF + 4 * DUR_W + 7) / 8) * 8;
  localparam int HOLD_OFF       = DUR_W + COUNT_BITS_DEF + 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 210;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // build_duration, present_duration
  logic                s_tuser;   // operation
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;   // frames_in_report, build_average, build_max,
                                  // present_average, present_max
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int mismatches;
  int reports_owed;

  windowed_duration_stats DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  wds_report_checker report_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .reports_owed (reports_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the receiver at random on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Count cycles in which no item moves on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("windowed_duration_stats_tb: done, errors");
    $finish;
  end

  // Mostly realistic frame times, with extremes and full-range values mixed in
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(20_000_000);
      5, 6: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item after a random gap; leave valid high on return
  task automatic send_item(input logic op, input logic [DUR_W-1:0] build_ns,
                           input logic [DUR_W-1:0] present_ns);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {present_ns, build_ns};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every owed report has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic write_interval(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                  sent;
    int                  flush_pct;
    logic [CFG_BITS-1:0] interval;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_RECORD;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Flush of an empty window, its durations ignored
    send_item(OP_FLUSH, '1, '1);
    // Partial window of extreme durations under the reset interval
    send_item(OP_RECORD, '0, '0);
    send_item(OP_RECORD, '1, '1);
    send_item(OP_RECORD, 32'd1, 32'hFFFF_FFFE);
    send_item(OP_RECORD, 32'hA5A5_5A5A, '0);
    send_item(OP_FLUSH, $urandom, $urandom);
    send_item(OP_FLUSH, '0, '0);
    // Zero interval: every record reports
    write_interval('0);
    send_item(OP_RECORD, '1, '0);
    send_item(OP_RECORD, '0, '1);
    // Lower the interval below the tally held mid-window
    write_interval(16'd5);
    repeat (4) send_item(OP_RECORD, pick_duration(), pick_duration());
    write_interval(16'd2);
    repeat (3) send_item(OP_RECORD, pick_duration(), pick_duration());
    // Largest interval, ended by a flush
    write_interval('1);
    repeat (3) send_item(OP_RECORD, pick_duration(), pick_duration());
    send_item(OP_FLUSH, $urandom, $urandom);

    // Random phases, each with its own interval and one of four idling and stalling patterns
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: interval = 16'd1;
        1: interval = CFG_BITS'($urandom_range(2, 12));
        2: interval = '1;
        3: interval = '0;
        4: interval = CFG_BITS'($urandom_range(13, 40));
        5: interval = 16'd3;
        6: interval = INTERVAL_RESET;
        default: interval = CFG_BITS'($urandom_range(1, 6));
      endcase
      write_interval(interval);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      flush_pct = (interval > 40) ? 8 : 3;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) == 0) begin
          drain();
        end else begin
          if ($urandom_range(99) < flush_pct) begin
            send_item(OP_FLUSH, $urandom, $urandom);
          end else begin
            send_item(OP_RECORD, pick_duration(), pick_duration());
          end
          sent++;
        end
      end
    end

    settle();
    if (mismatches == 0 && reports_owed == 0) begin
      $display("windowed_duration_stats_tb: done, clean");
    end else begin
      $display("windowed_duration_stats_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/wds_pkg.sv
hdl/wds_datapath.sv
hdl/wds_ctrl.sv
hdl/windowed_duration_stats.sv
hdl/wds_checker.sv
test/wds_report_checker.sv
test/windowed_duration_stats_tb.sv
